// ===== hdl/glsw_pkg.sv =====
// ----------------------------------------------------------------------------
// glsw_pkg
// Shared types, widths and constants of the Gaussian local similarity warp.
// ----------------------------------------------------------------------------
package glsw_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;
  localparam int unsigned COORD_WIDTH_DEF     = 16;

  // Register stages from the input word to the output register.
  localparam int unsigned NUM_STAGES = 9;

  // Configuration register widths.
  localparam int unsigned ROT_W      = 16;
  localparam int unsigned OFS_W      = 20;
  localparam int unsigned CTR_W      = 16;
  localparam int unsigned FALL_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Distance magnitude that still gets squared, squares and their clamped sum.
  localparam int unsigned DIST_W = 17;
  localparam int unsigned SQ_W   = 2 * DIST_W;
  localparam int unsigned S_W    = SQ_W + 1;

  // Falloff weight, unsigned Q1.15.
  localparam int unsigned F_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_COS     = 3'd0,
    CFG_ROT_SIN     = 3'd1,
    CFG_OFFSET_X    = 3'd2,
    CFG_OFFSET_Y    = 3'd3,
    CFG_CENTER_X    = 3'd4,
    CFG_CENTER_Y    = 3'd5,
    CFG_FALLOFF_INV = 3'd6
  } cfg_index_e;

  // Reset values of the configuration registers.
  localparam logic [ROT_W-1:0] ROT_COS_RST = 16'h4000;

  // Configuration register file.
  typedef struct packed {
    logic signed [ROT_W-1:0]  rot_cos;
    logic signed [ROT_W-1:0]  rot_sin;
    logic signed [OFS_W-1:0]  offset_x;
    logic signed [OFS_W-1:0]  offset_y;
    logic signed [CTR_W-1:0]  center_x;
    logic signed [CTR_W-1:0]  center_y;
    logic        [FALL_W-1:0] falloff_inv;
  } glsw_cfg_t;

  // Width of the transformed coordinate in Q.4 for a given coordinate width.
  function automatic int unsigned v2_width(input int unsigned cw);
    int unsigned prod_w;
    prod_w = (cw + 16 > 33) ? cw + 16 : 33;
    return prod_w + 2 - 14;
  endfunction

endpackage

// ===== hdl/glsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// glsw_ctrl
// Valid bits and stage load enables of the warp pipeline.
// ----------------------------------------------------------------------------
module glsw_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [glsw_pkg::NUM_STAGES-1:0] stage_ld_o
);
  import glsw_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] ready;

  // A stage loads when it is empty or its word moves on, so bubbles collapse.
  always_comb begin
    ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign stage_ld_o  = ready;

`ifndef ASSERT_OFF
  // An accepted word always occupies the first stage afterwards.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted word did not enter the pipeline");

  // The input side only stalls when every stage holds a word.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled while the pipeline has a bubble");

  // A stalled word in the stage before the output is never dropped.
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NUM_STAGES-2] && !ready[NUM_STAGES-1] |=> valid_q[NUM_STAGES-2])
    else $error("stalled word lost before the output register");
`endif

endmodule

// ===== hdl/glsw_geom.sv =====
// ----------------------------------------------------------------------------
// glsw_geom
// Inverse similarity transform and squared distance terms, two stages.
// ----------------------------------------------------------------------------
module glsw_geom #(
  parameter int unsigned COORD_WIDTH = glsw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                 clk_i,
  input  logic [1:0]                                           ld_i,
  input  glsw_pkg::glsw_cfg_t                                  cfg_i,
  input  logic signed [COORD_WIDTH-1:0]                        point_x_i,
  input  logic signed [COORD_WIDTH-1:0]                        point_y_i,
  output logic signed [COORD_WIDTH-1:0]                        v_x_o,
  output logic signed [COORD_WIDTH-1:0]                        v_y_o,
  output logic signed [glsw_pkg::v2_width(COORD_WIDTH)-1:0]    v2_x_o,
  output logic signed [glsw_pkg::v2_width(COORD_WIDTH)-1:0]    v2_y_o,
  output logic [glsw_pkg::SQ_W-1:0]                            sq_x_o,
  output logic [glsw_pkg::SQ_W-1:0]                            sq_y_o,
  output logic                                                 far_o
);
  import glsw_pkg::*;

  localparam int unsigned PW    = COORD_WIDTH + ROT_W;
  localparam int unsigned V2_W  = v2_width(COORD_WIDTH);
  localparam int unsigned SUM_W = V2_W + 14;
  localparam int unsigned DX_W  = ((COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W) + 1;
  localparam logic [SUM_W-1:0] RND_HALF = {{(SUM_W - 14){1'b0}}, 1'b1, 13'd0};

  // Stage 0: matrix products and distance magnitudes.
  logic signed [PW-1:0]          ax_q, by_q, ay_q, bx_q;
  logic signed [PW-1:0]          ax_d, by_d, ay_d, bx_d;
  logic signed [COORD_WIDTH-1:0] vx0_q, vy0_q;
  logic signed [DX_W-1:0]        dx, dy;
  logic        [DX_W-1:0]        mag_x, mag_y;
  logic        [DIST_W-1:0]      adx_q, ady_q;
  logic                          far0_q, far0_d;

  always_comb begin
    ax_d   = $signed(cfg_i.rot_cos) * point_x_i;
    by_d   = $signed(cfg_i.rot_sin) * point_y_i;
    ay_d   = $signed(cfg_i.rot_cos) * point_y_i;
    bx_d   = $signed(cfg_i.rot_sin) * point_x_i;
    dx     = DX_W'(point_x_i) - DX_W'($signed(cfg_i.center_x));
    dy     = DX_W'(point_y_i) - DX_W'($signed(cfg_i.center_y));
    mag_x  = dx[DX_W-1] ? (~dx + 1'b1) : dx;
    mag_y  = dy[DX_W-1] ? (~dy + 1'b1) : dy;
    far0_d = (|mag_x[DX_W-1:DIST_W]) || (|mag_y[DX_W-1:DIST_W]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      ax_q   <= ax_d;
      by_q   <= by_d;
      ay_q   <= ay_d;
      bx_q   <= bx_d;
      vx0_q  <= point_x_i;
      vy0_q  <= point_y_i;
      adx_q  <= mag_x[DIST_W-1:0];
      ady_q  <= mag_y[DIST_W-1:0];
      far0_q <= far0_d;
    end
  end

  // Stage 1: add offsets with rounding, square the distance components.
  logic [SUM_W-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = SUM_W'(ax_q) + SUM_W'(by_q) + (SUM_W'($signed(cfg_i.offset_x)) << 14) + RND_HALF;
    sum_y = SUM_W'(ay_q) - SUM_W'(bx_q) + (SUM_W'($signed(cfg_i.offset_y)) << 14) + RND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      v_x_o  <= vx0_q;
      v_y_o  <= vy0_q;
      v2_x_o <= $signed(sum_x[SUM_W-1:14]);
      v2_y_o <= $signed(sum_y[SUM_W-1:14]);
      sq_x_o <= adx_q * adx_q;
      sq_y_o <= ady_q * ady_q;
      far_o  <= far0_q;
    end
  end

endmodule

// ===== hdl/glsw_weight.sv =====
// ----------------------------------------------------------------------------
// glsw_weight
// Gaussian falloff weight from the squared distance, five stages.
// ----------------------------------------------------------------------------
module glsw_weight #(
  parameter int unsigned EXP_TABLE_DEPTH = glsw_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic [4:0]                   ld_i,
  input  logic [glsw_pkg::SQ_W-1:0]    sq_x_i,
  input  logic [glsw_pkg::SQ_W-1:0]    sq_y_i,
  input  logic                         far_i,
  input  logic [glsw_pkg::FALL_W-1:0]  falloff_inv_i,
  output logic [glsw_pkg::F_W-1:0]     f_o
);
  import glsw_pkg::*;

  localparam int unsigned IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DEP_W  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned LO_W   = 18;
  localparam int unsigned HI_W   = S_W - LO_W;
  localparam int unsigned PLO_W  = LO_W + FALL_W;
  localparam int unsigned PHI_W  = HI_W + FALL_W;
  localparam int unsigned PROD_W = PHI_W + LO_W;
  localparam logic [S_W-1:0]   S_MAX   = {1'b1, {(S_W - 1){1'b0}}};
  localparam logic [DEP_W-1:0] DEPTH_C = DEP_W'(EXP_TABLE_DEPTH);

  // Table argument step 2^29/depth as a whole part and a remainder.
  localparam logic [63:0] Y_DEN    = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] Y_STEP_Q = (64'd1 << 29) / 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] Y_STEP_R = (64'd1 << 29) % 64'(EXP_TABLE_DEPTH);

  typedef logic [F_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(-16*i/depth) in UQ1.15: Taylor series of e^-y, then squared six times.
  // The argument y = floor(i * 2^29 / depth) is stepped from entry to entry.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] y, y_rem, term, pos, neg, r;
    y     = 64'd0;
    y_rem = 64'd0;
    for (int i = 0; i < int'(EXP_TABLE_DEPTH); i++) begin
      term = 64'd1 << 31;
      pos  = term;
      term = (term * y) >> 31;                neg  = term;
      term = ((term * y) >> 31) / 64'd2;      pos += term;
      term = ((term * y) >> 31) / 64'd3;      neg += term;
      term = ((term * y) >> 31) / 64'd4;      pos += term;
      term = ((term * y) >> 31) / 64'd5;      neg += term;
      term = ((term * y) >> 31) / 64'd6;      pos += term;
      term = ((term * y) >> 31) / 64'd7;      neg += term;
      term = ((term * y) >> 31) / 64'd8;      pos += term;
      term = ((term * y) >> 31) / 64'd9;      neg += term;
      term = ((term * y) >> 31) / 64'd10;     pos += term;
      term = ((term * y) >> 31) / 64'd11;     neg += term;
      term = ((term * y) >> 31) / 64'd12;     pos += term;
      r = (pos > neg) ? pos - neg : 64'd0;
      if (r > (64'd1 << 31)) r = 64'd1 << 31;
      for (int k = 0; k < 6; k++) begin
        r = (r * r + (64'd1 << 30)) >> 31;
      end
      r = (r + (64'd1 << 15)) >> 16;
      if (r > 64'd32768) r = 64'd32768;
      tab[i] = r[F_W-1:0];
      // Advance the argument to the next entry.
      y     = y + Y_STEP_Q;
      y_rem = y_rem + Y_STEP_R;
      if (y_rem >= Y_DEN) begin
        y_rem = y_rem - Y_DEN;
        y     = y + 64'd1;
      end
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_table();

  // Stage 2: sum of squares, clamped to 2^34.
  logic [S_W-1:0] s_sum, s_q;

  always_comb begin
    s_sum = S_W'(sq_x_i) + S_W'(sq_y_i);
    if (far_i || (s_sum[S_W-1] && (|s_sum[S_W-2:0]))) begin
      s_sum = S_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      s_q <= s_sum;
    end
  end

  // Stage 3: scale by the falloff in two partial products.
  logic [PLO_W-1:0] plo_q;
  logic [PHI_W-1:0] phi_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      plo_q <= s_q[LO_W-1:0] * falloff_inv_i;
      phi_q <= s_q[S_W-1:LO_W] * falloff_inv_i;
    end
  end

  // Stage 4: merge partial products; the argument halves into Q.28.
  logic [PROD_W-1:0] prod;
  logic [31:0]       t_q;
  logic              zero4_q;

  assign prod = {phi_q, {LO_W{1'b0}}} + PROD_W'(plo_q);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      t_q     <= prod[32:1];
      zero4_q <= |prod[PROD_W-1:33];
    end
  end

  // Stage 5: table index floor(t * depth / 2^32).
  logic [31+DEP_W:0] idx_prod;
  logic [IDX_W-1:0]  idx_q;
  logic              zero5_q;

  assign idx_prod = t_q * DEPTH_C;

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      idx_q   <= idx_prod[32 +: IDX_W];
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: table read; arguments of 16 and above give zero weight.
  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      f_o <= zero5_q ? '0 : EXP_TAB[idx_q];
    end
  end

endmodule

// ===== hdl/glsw_blend.sv =====
// ----------------------------------------------------------------------------
// glsw_blend
// Weighted blend of the point and its transform, with output saturation.
// ----------------------------------------------------------------------------
module glsw_blend #(
  parameter int unsigned COORD_WIDTH = glsw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                              clk_i,
  input  logic [6:0]                                        ld_i,
  input  logic signed [COORD_WIDTH-1:0]                     v_x_i,
  input  logic signed [COORD_WIDTH-1:0]                     v_y_i,
  input  logic signed [glsw_pkg::v2_width(COORD_WIDTH)-1:0] v2_x_i,
  input  logic signed [glsw_pkg::v2_width(COORD_WIDTH)-1:0] v2_y_i,
  input  logic [glsw_pkg::F_W-1:0]                          f_i,
  output logic signed [COORD_WIDTH-1:0]                     warped_x_o,
  output logic signed [COORD_WIDTH-1:0]                     warped_y_o
);
  import glsw_pkg::*;

  localparam int unsigned V2_W  = v2_width(COORD_WIDTH);
  localparam int unsigned D_W   = V2_W + 1;
  localparam int unsigned M_W   = D_W + F_W + 1;
  localparam int unsigned R_W   = M_W - 15;
  localparam int unsigned O_W   = R_W + 1;
  localparam int unsigned DLY_N = 4;
  localparam logic [M_W-1:0] RND_HALF = {{(M_W - 15){1'b0}}, 1'b1, 14'd0};
  localparam logic signed [O_W-1:0] SAT_HI =
    {{(O_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [O_W-1:0] SAT_LO = ~SAT_HI;

  // Stages 2 to 5: coordinates wait while the weight is worked out.
  logic signed [COORD_WIDTH-1:0] vx_dly_q  [DLY_N];
  logic signed [COORD_WIDTH-1:0] vy_dly_q  [DLY_N];
  logic signed [V2_W-1:0]        v2x_dly_q [DLY_N];
  logic signed [V2_W-1:0]        v2y_dly_q [DLY_N];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      vx_dly_q[0]  <= v_x_i;
      vy_dly_q[0]  <= v_y_i;
      v2x_dly_q[0] <= v2_x_i;
      v2y_dly_q[0] <= v2_y_i;
    end
    for (int k = 1; k < DLY_N; k++) begin
      if (ld_i[k]) begin
        vx_dly_q[k]  <= vx_dly_q[k-1];
        vy_dly_q[k]  <= vy_dly_q[k-1];
        v2x_dly_q[k] <= v2x_dly_q[k-1];
        v2y_dly_q[k] <= v2y_dly_q[k-1];
      end
    end
  end

  // Stage 6: displacement of the transformed point.
  logic signed [COORD_WIDTH-1:0] vx6_q, vy6_q;
  logic signed [D_W-1:0]         dx6_q, dy6_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      vx6_q <= vx_dly_q[DLY_N-1];
      vy6_q <= vy_dly_q[DLY_N-1];
      dx6_q <= D_W'(v2x_dly_q[DLY_N-1]) - D_W'(vx_dly_q[DLY_N-1]);
      dy6_q <= D_W'(v2y_dly_q[DLY_N-1]) - D_W'(vy_dly_q[DLY_N-1]);
    end
  end

  // Stage 7: displacement times the weight.
  logic signed [COORD_WIDTH-1:0] vx7_q, vy7_q;
  logic signed [M_W-1:0]         mx7_q, my7_q;
  logic signed [F_W:0]           f_s;

  assign f_s = $signed({1'b0, f_i});

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      vx7_q <= vx6_q;
      vy7_q <= vy6_q;
      mx7_q <= f_s * dx6_q;
      my7_q <= f_s * dy6_q;
    end
  end

  // Stage 8: round, add to the point and saturate.
  logic [M_W-1:0]        mx_r, my_r;
  logic signed [O_W-1:0] ox, oy, ox_sat, oy_sat;

  always_comb begin
    mx_r = mx7_q + RND_HALF;
    my_r = my7_q + RND_HALF;
    ox   = $signed(O_W'(vx7_q) + O_W'($signed(mx_r[M_W-1:15])));
    oy   = $signed(O_W'(vy7_q) + O_W'($signed(my_r[M_W-1:15])));
    if (ox > SAT_HI) begin
      ox_sat = SAT_HI;
    end else if (ox < SAT_LO) begin
      ox_sat = SAT_LO;
    end else begin
      ox_sat = ox;
    end
    if (oy > SAT_HI) begin
      oy_sat = SAT_HI;
    end else if (oy < SAT_LO) begin
      oy_sat = SAT_LO;
    end else begin
      oy_sat = oy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[6]) begin
      warped_x_o <= ox_sat[COORD_WIDTH-1:0];
      warped_y_o <= oy_sat[COORD_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/gaussian_local_similarity_warp_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_local_similarity_warp_top
// Gaussian-weighted local similarity warp of Q12.4 points, one per clock unless the output stalls.
// ----------------------------------------------------------------------------
// The block takes one point per clock while the output side accepts results
// and returns the warped positions with no gaps in a continuous stream. The
// nine-stage pipeline has two stages for the inverse transform and the
// distance squares, five for the falloff weight (sum, split multiply, merge,
// table index, exp table read) and two for the weighted blend, the last of
// which is the output register. A stall on the output side holds every word
// that has no empty stage ahead of it; empty stages keep taking points while
// a result waits. Configuration registers take effect for points accepted
// after the write and must only be written while the pipeline is empty.
module gaussian_local_similarity_warp_top #(
  parameter int unsigned EXP_TABLE_DEPTH = glsw_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int unsigned COORD_WIDTH     = glsw_pkg::COORD_WIDTH_DEF,
  localparam int unsigned TDATA_W        = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [glsw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [glsw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input points.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,   // point_x, point_y, zero pad
  // Warped points.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata    // warped_x, warped_y, zero pad
);
  import glsw_pkg::*;

  localparam int unsigned V2_W = v2_width(COORD_WIDTH);

  // Configuration registers.
  glsw_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROT_COS:     cfg_d.rot_cos     = cfg_data_i[ROT_W-1:0];
        CFG_ROT_SIN:     cfg_d.rot_sin     = cfg_data_i[ROT_W-1:0];
        CFG_OFFSET_X:    cfg_d.offset_x    = cfg_data_i[OFS_W-1:0];
        CFG_OFFSET_Y:    cfg_d.offset_y    = cfg_data_i[OFS_W-1:0];
        CFG_CENTER_X:    cfg_d.center_x    = cfg_data_i[CTR_W-1:0];
        CFG_CENTER_Y:    cfg_d.center_y    = cfg_data_i[CTR_W-1:0];
        CFG_FALLOFF_INV: cfg_d.falloff_inv = cfg_data_i[FALL_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rot_cos: ROT_COS_RST, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Pipeline control.
  logic [NUM_STAGES-1:0] stage_ld;

  glsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stage_ld_o  (stage_ld)
  );

  // Transform and distance.
  logic signed [COORD_WIDTH-1:0] point_x, point_y, v_x, v_y;
  logic signed [V2_W-1:0]        v2_x, v2_y;
  logic [SQ_W-1:0]               sq_x, sq_y;
  logic                          far;

  assign point_x = $signed(s_axis_tdata[COORD_WIDTH-1:0]);
  assign point_y = $signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

  glsw_geom #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_geom (
    .clk_i     (clk_i),
    .ld_i      (stage_ld[1:0]),
    .cfg_i     (cfg_q),
    .point_x_i (point_x),
    .point_y_i (point_y),
    .v_x_o     (v_x),
    .v_y_o     (v_y),
    .v2_x_o    (v2_x),
    .v2_y_o    (v2_y),
    .sq_x_o    (sq_x),
    .sq_y_o    (sq_y),
    .far_o     (far)
  );

  // Falloff weight.
  logic [F_W-1:0] weight;

  glsw_weight #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_weight (
    .clk_i         (clk_i),
    .ld_i          (stage_ld[6:2]),
    .sq_x_i        (sq_x),
    .sq_y_i        (sq_y),
    .far_i         (far),
    .falloff_inv_i (cfg_q.falloff_inv),
    .f_o           (weight)
  );

  // Blend and output register.
  logic signed [COORD_WIDTH-1:0] warped_x, warped_y;

  glsw_blend #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_blend (
    .clk_i      (clk_i),
    .ld_i       (stage_ld[8:2]),
    .v_x_i      (v_x),
    .v_y_i      (v_y),
    .v2_x_i     (v2_x),
    .v2_y_i     (v2_y),
    .f_i        (weight),
    .warped_x_o (warped_x),
    .warped_y_o (warped_y)
  );

  assign m_axis_tdata = TDATA_W'({warped_y, warped_x});

endmodule

// ===== test/tb_gaussian_local_similarity_warp_top.sv =====
// ----------------------------------------------------------------------------
// tb_gaussian_local_similarity_warp_top
// Self-checking bench for the Gaussian local similarity warp.
// ----------------------------------------------------------------------------
// Points are streamed into the block and every warped point coming out is
// compared field by field with the oldest pending prediction. A directed
// table covers the reset state, saturation, the rotation extremes, the
// falloff extremes and an ignored register index. Random phases follow, each
// with a fresh register setting written while the pipeline is empty. Both
// stream sides idle at random, with some phases running at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gaussian_local_similarity_warp_top;
  import glsw_pkg::*;

  localparam int unsigned CW          = COORD_WIDTH_DEF;
  localparam int unsigned EXP_DEPTH   = EXP_TABLE_DEPTH_DEF;
  localparam int unsigned TDATA_W     = ((2 * CW + 7) / 8) * 8;
  localparam int unsigned NUM_PHASES  = 13;
  localparam int unsigned PHASE_WORDS = 150;
  localparam int unsigned CYCLE_LIMIT = 800_000;

  // Index that no register answers to.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

  localparam longint unsigned S_CLAMP  = 64'd1 << SQ_W;
  localparam longint unsigned T_CUTOFF = 64'd16 << 28;
  localparam longint          DIST_LIM = longint'(1) << DIST_W;

  // A point as it travels in tdata, x in the low bits.
  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } warp_point_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PREDICT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic signed [CW-1:0]  ex;
    logic signed [CW-1:0]  ey;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // point_x, point_y
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;        // warped_x, warped_y

  // Typed expectation that travels alongside the word on the input side.
  logic                  row_typed     = 1'b0;
  warp_point_t           row_exp       = '0;

  glsw_cfg_t             warp_cfg;
  logic [F_W-1:0]        exp_lut [EXP_DEPTH];
  warp_point_t           warp_expected_q [$];
  stim_row_t             dir_rows [$];
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count    = 0;
  bit                    free_run       = 1'b0;

  gaussian_local_similarity_warp_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Exp table in UQ1.15: Taylor series of a sixty-fourth of the argument,
  // then squared six times.
  function automatic void build_exp_lut();
    longint unsigned y, term, pos, neg, r;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      y    = (longint'(i) << 31) / (4 * EXP_DEPTH);
      term = 64'h8000_0000;
      pos  = term;
      neg  = 0;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * y) >> 31) / n;
        if (n % 2 == 1) neg += term;
        else pos += term;
      end
      r = (pos > neg) ? pos - neg : 0;
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      for (int k = 0; k < 6; k++) r = (r * r + 64'h4000_0000) >> 31;
      r = (r + 64'h8000) >> 16;
      if (r > 32768) r = 32768;
      exp_lut[i] = r[F_W-1:0];
    end
  endfunction

  // Blend one axis toward its transformed value and saturate.
  function automatic logic signed [CW-1:0] blend_axis(input longint v, input longint v2,
                                                      input longint unsigned f);
    longint o, hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    o  = v + ((longint'(f) * (v2 - v) + 16384) >>> 15);
    if (o > hi) o = hi;
    if (o < lo) o = lo;
    return o[CW-1:0];
  endfunction

  // Warped position of one point under the current register setting.
  function automatic warp_point_t predict_warp(input logic signed [CW-1:0] px,
                                               input logic signed [CW-1:0] py);
    longint vx, vy, a, b, ox, oy, dx, dy, v2x, v2y, adx, ady;
    longint unsigned s, t, f;
    warp_point_t res;
    vx  = px;
    vy  = py;
    a   = $signed(warp_cfg.rot_cos);
    b   = $signed(warp_cfg.rot_sin);
    ox  = $signed(warp_cfg.offset_x);
    oy  = $signed(warp_cfg.offset_y);
    dx  = vx - longint'($signed(warp_cfg.center_x));
    dy  = vy - longint'($signed(warp_cfg.center_y));
    v2x = (a * vx + b * vy + ox * 16384 + 8192) >>> 14;
    v2y = (a * vy - b * vx + oy * 16384 + 8192) >>> 14;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    // A far point clamps the squared distance.
    if (adx >= DIST_LIM || ady >= DIST_LIM) s = S_CLAMP;
    else s = adx * adx + ady * ady;
    if (s > S_CLAMP) s = S_CLAMP;
    t = (s * longint'(warp_cfg.falloff_inv)) >> 1;
    if (t >= T_CUTOFF) f = 0;
    else f = exp_lut[int'(((t * EXP_DEPTH) >> 32) % EXP_DEPTH)];
    res.x = blend_axis(vx, v2x, f);
    res.y = blend_axis(vy, v2y, f);
    return res;
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Register value for a random phase, extremes included.
  function automatic logic [CFG_DATA_W-1:0] rand_cfg_value(input logic [CFG_IDX_W-1:0] idx);
    int unsigned sel;
    logic [31:0] r;
    sel = $urandom_range(0, 9);
    r   = $urandom();
    case (idx)
      CFG_OFFSET_X, CFG_OFFSET_Y: begin
        if (sel == 0) return 24'h080000;
        if (sel == 1) return 24'h07FFFF;
        if (sel < 7) return {{11{r[12]}}, r[12:0]};
        return r[CFG_DATA_W-1:0];
      end
      CFG_FALLOFF_INV: begin
        if (sel == 0) return '0;
        if (sel == 1) return 24'hFFFFFF;
        if (sel < 5) return CFG_DATA_W'($urandom_range(1, 64));
        if (sel < 8) return CFG_DATA_W'($urandom_range(0, 4095));
        return r[CFG_DATA_W-1:0];
      end
      default: begin
        if (sel == 0) return 24'h008000;
        if (sel == 1) return 24'h007FFF;
        return r[CFG_DATA_W-1:0];
      end
    endcase
  endfunction

  // Let the pipeline run dry; every word yields one result.
  task automatic wait_pipeline_empty();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (warp_expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROT_COS:     warp_cfg.rot_cos     = data[ROT_W-1:0];
      CFG_ROT_SIN:     warp_cfg.rot_sin     = data[ROT_W-1:0];
      CFG_OFFSET_X:    warp_cfg.offset_x    = data[OFS_W-1:0];
      CFG_OFFSET_Y:    warp_cfg.offset_y    = data[OFS_W-1:0];
      CFG_CENTER_X:    warp_cfg.center_x    = data[CTR_W-1:0];
      CFG_CENTER_Y:    warp_cfg.center_y    = data[CTR_W-1:0];
      CFG_FALLOFF_INV: warp_cfg.falloff_inv = data[FALL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one point after a random gap and hold it until it is taken.
  task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                            input logic typed, input warp_point_t ex);
    int unsigned gap;
    gap = free_run ? 0 : rand_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    row_typed     <= typed;
    row_exp       <= ex;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Output side back-pressure.
  initial begin : sink_stall
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (free_run) begin
        m_axis_tready <= 1'b1;
        hold = 0;
      end else if (hold != 0) begin
        hold--;
      end else if (m_axis_tready) begin
        hold = rand_gap();
        if (hold != 0) begin
          m_axis_tready <= 1'b0;
          hold--;
        end
      end else begin
        m_axis_tready <= 1'b1;
        hold = $urandom_range(0, 11);
      end
    end
  end

  // Record a prediction for every accepted point and check every result word.
  always @(posedge clk_i) begin : result_monitor
    warp_point_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (row_typed) warp_expected_q.push_back(row_exp);
        else warp_expected_q.push_back(predict_warp(s_axis_tdata[CW-1:0],
                                                    s_axis_tdata[2*CW-1:CW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2*CW-1:0];
        if (warp_expected_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got x=%0d y=%0d",
                   $time, got.x, got.y);
          mismatch_count++;
        end else begin
          want = warp_expected_q.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: warped_x mismatch, expected %0d, got %0d", $time, want.x, got.x);
            mismatch_count++;
          end
          if (got.y !== want.y) begin
            $display("%0t: warped_y mismatch, expected %0d, got %0d", $time, want.y, got.y);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [CW-1:0] px, py, jx, jy;
    logic [31:0] rnd;
    int unsigned sh;

    warp_cfg         = '0;
    warp_cfg.rot_cos = ROT_COS_RST;
    build_exp_lut();

    // Directed rows. Right after reset the warp is the identity.
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sh7FFF, 16'sh8000,
                         16'sh7FFF, 16'sh8000});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sh8000, 16'sh7FFF,
                         16'sh8000, 16'sh7FFF});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sh5555, 16'shAAAA,
                         16'sh5555, 16'shAAAA});
    // Offset extremes push the full warp into saturation.
    dir_rows.push_back('{ROW_CFG, CFG_OFFSET_X, 24'h07FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_OFFSET_Y, 24'h080000, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sd0, 16'sd0,
                         16'sh7FFF, 16'sh8000});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sh7FFF, 16'sh8000,
                         16'sh7FFF, 16'sh8000});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sh8000, 16'sh7FFF,
                         16'sh7FFF, 16'sh8000});
    dir_rows.push_back('{ROW_CFG, CFG_OFFSET_X, 24'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_OFFSET_Y, 24'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    // Rotation and scale extremes with zero falloff.
    dir_rows.push_back('{ROW_CFG, CFG_ROT_COS, 24'h008000, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_ROT_SIN, 24'h007FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh7FFF, 16'sh7FFF,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh8000, 16'sh8000,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sd100, -16'sd37, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_ROT_SIN, 24'hFF8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh8000, 16'sh7FFF,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sd12345, -16'sd4321,
                         16'sd0, 16'sd0});
    // Largest falloff: a far point keeps its place, the center takes the full warp.
    dir_rows.push_back('{ROW_CFG, CFG_CENTER_X, 24'h007FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_CENTER_Y, 24'h008000, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_FALLOFF_INV, 24'hFFFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_TYPED, CFG_IDX_NONE, 24'h0, 16'sh8000, 16'sh7FFF,
                         16'sh8000, 16'sh7FFF});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh7FFF, 16'sh8000,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh7FFE, 16'sh8000,
                         16'sd0, 16'sd0});
    // Smallest nonzero falloff, then a mid-table one.
    dir_rows.push_back('{ROW_CFG, CFG_CENTER_X, 24'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_CENTER_Y, 24'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_FALLOFF_INV, 24'h000001, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh7FFF, 16'sh7FFF,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sh8000, 16'sh8000,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_CFG, CFG_FALLOFF_INV, 24'h000100, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sd4096, -16'sd4096,
                         16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sd800, 16'sd300, 16'sd0, 16'sd0});
    // A write to an unused index must leave every register alone.
    dir_rows.push_back('{ROW_CFG, CFG_IDX_NONE, 24'hFFFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, -16'sd1, 16'sd1, 16'sd0, 16'sd0});
    dir_rows.push_back('{ROW_PREDICT, CFG_IDX_NONE, 24'h0, 16'sd2000, -16'sd1500,
                         16'sd0, 16'sd0});

    // Reset.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          wait_pipeline_empty();
          cfg_write(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
        end
        ROW_TYPED:
          send_point(dir_rows[i].px, dir_rows[i].py, 1'b1, {dir_rows[i].ey, dir_rows[i].ex});
        default:
          send_point(dir_rows[i].px, dir_rows[i].py, 1'b0, '0);
      endcase
    end

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_pipeline_empty();
      free_run = ($urandom_range(0, 3) == 0);
      for (int r = CFG_ROT_COS; r <= CFG_FALLOFF_INV; r++)
        cfg_write(r[CFG_IDX_W-1:0], rand_cfg_value(r[CFG_IDX_W-1:0]));
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_IDX_NONE, CFG_DATA_W'($urandom()));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        rnd = $urandom();
        if ($urandom_range(0, 1) == 1) begin
          // Near the falloff center, where the weight varies.
          sh = $urandom_range(2, 14);
          jx = rnd[CW-1:0];
          jy = rnd[2*CW-1:CW];
          px = warp_cfg.center_x + (jx >>> sh);
          py = warp_cfg.center_y + (jy >>> sh);
        end else begin
          px = rnd[CW-1:0];
          py = rnd[2*CW-1:CW];
        end
        send_point(px, py, 1'b0, '0);
      end
    end

    // Drain and report.
    free_run = 1'b0;
    wait_pipeline_empty();
    repeat (4 * NUM_STAGES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
